@@ hw/rtl/rlit_pkg.sv @@
// Shared types and constants for the run/lumi interval tracker.
// Used by rlit_cell and run_lumi_interval_tracker_unit; no dependencies.
package rlit_pkg;

  localparam int LUMI_BITS      = 16;
  localparam int RUN_BITS       = 32;
  localparam int RIDX_BITS      = 6;
  localparam int DEPTH_MAX      = 1024;
  localparam int IDX_BITS       = $clog2(DEPTH_MAX);
  localparam int MASK_DEPTH_DEF = 64;
  localparam int SEEN_DEPTH_DEF = 64;

  localparam logic [LUMI_BITS-1:0] LUMI_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_EVENT = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_MASKED      = 4'd0,
    ST_COVERED     = 4'd1,
    ST_LOW_EXT     = 4'd2,
    ST_HIGH_EXT    = 4'd3,
    ST_NEW         = 4'd4,
    ST_FULL        = 4'd5,
    ST_MASK_LOADED = 4'd6,
    ST_MASK_FULL   = 4'd7,
    ST_READ        = 4'd8,
    ST_CLEARED     = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]           operation;
    logic [RUN_BITS-1:0]  run_number;
    logic [LUMI_BITS-1:0] range_low;
    logic [LUMI_BITS-1:0] range_high;
    logic [LUMI_BITS-1:0] event_lumi;
    logic [RIDX_BITS-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic [3:0]           status;
    logic [RIDX_BITS-1:0] entry_index;
    logic                 entry_valid;
    logic [RUN_BITS-1:0]  entry_run;
    logic [LUMI_BITS-1:0] entry_low;
    logic [LUMI_BITS-1:0] entry_high;
  } result_t;

  // transaction travelling down the cell chain, with what it has collected so far
  typedef struct packed {
    logic                 valid;
    op_t                  op;
    logic [RUN_BITS-1:0]  run;
    logic [LUMI_BITS-1:0] lumi;
    logic [LUMI_BITS-1:0] range_low;
    logic [LUMI_BITS-1:0] range_high;
    logic [RIDX_BITS-1:0] read_index;
    logic                 mask_hit;
    logic                 hit;
    logic [IDX_BITS-1:0]  hit_idx;
    logic [LUMI_BITS-1:0] hit_low;
    logic [LUMI_BITS-1:0] hit_high;
    logic                 ext;
    logic                 ext_hi;
    logic [IDX_BITS-1:0]  ext_idx;
    logic [LUMI_BITS-1:0] ext_low;
    logic [LUMI_BITS-1:0] ext_high;
  } token_t;

  // broadcast entry write
  typedef struct packed {
    logic                 mask_we;
    logic                 seen_we;
    logic [IDX_BITS-1:0]  idx;
    logic [RUN_BITS-1:0]  run;
    logic [LUMI_BITS-1:0] low;
    logic [LUMI_BITS-1:0] high;
  } wr_t;

endpackage

@@ hw/rtl/rlit_cell.sv @@
// One chain cell: holds mask entry IDX and seen entry IDX, checks the passing
// transaction against them and hands it on registered. Depends on rlit_pkg.
module rlit_cell #(
  parameter int IDX    = 0,
  parameter int MCNT_W = 7,
  parameter int SCNT_W = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [MCNT_W-1:0]     mask_count,
  input  logic [SCNT_W-1:0]     seen_count,
  input  rlit_pkg::wr_t         wr,
  input  rlit_pkg::token_t      tin,
  output rlit_pkg::token_t      tout
);

  logic [rlit_pkg::RUN_BITS-1:0]  mrun;
  logic [rlit_pkg::LUMI_BITS-1:0] mlo;
  logic [rlit_pkg::LUMI_BITS-1:0] mhi;
  logic [rlit_pkg::RUN_BITS-1:0]  srun;
  logic [rlit_pkg::LUMI_BITS-1:0] slo;
  logic [rlit_pkg::LUMI_BITS-1:0] shi;

  logic             mocc;
  logic             socc;
  logic             m_cov;
  logic             run_eq;
  logic             s_cov;
  logic             lo_touch;
  logic             hi_touch;
  logic             rd_hit;
  logic             here;
  rlit_pkg::token_t t;

  assign here = (wr.idx == rlit_pkg::IDX_BITS'(IDX));

  always_ff @(posedge clk) begin
    if (wr.mask_we && here) begin
      mrun <= wr.run;
      mlo  <= wr.low;
      mhi  <= wr.high;
    end
    if (wr.seen_we && here) begin
      srun <= wr.run;
      slo  <= wr.low;
      shi  <= wr.high;
    end
  end

  assign mocc     = (int'(mask_count) > IDX);
  assign socc     = (int'(seen_count) > IDX);
  assign m_cov    = mocc && (mrun == tin.run) && (mlo <= tin.lumi) && (mhi >= tin.lumi);
  assign run_eq   = socc && (srun == tin.run);
  assign s_cov    = run_eq && (slo <= tin.lumi) && (shi >= tin.lumi);
  assign lo_touch = (tin.lumi != rlit_pkg::LUMI_MAX) &&
                    (slo == tin.lumi + rlit_pkg::LUMI_BITS'(1));
  assign hi_touch = (tin.lumi != '0) && (shi == tin.lumi - rlit_pkg::LUMI_BITS'(1));
  assign rd_hit   = socc &&
                    (rlit_pkg::IDX_BITS'(tin.read_index) == rlit_pkg::IDX_BITS'(IDX));

  always_comb begin
    t = tin;
    if (tin.op == rlit_pkg::OP_EVENT) begin
      if (m_cov) begin
        t.mask_hit = 1'b1;
      end
      if (s_cov && !tin.hit) begin
        t.hit      = 1'b1;
        t.hit_idx  = rlit_pkg::IDX_BITS'(IDX);
        t.hit_low  = slo;
        t.hit_high = shi;
      end
      if (run_eq && (lo_touch || hi_touch) && !tin.ext) begin
        t.ext      = 1'b1;
        t.ext_hi   = !lo_touch;
        t.ext_idx  = rlit_pkg::IDX_BITS'(IDX);
        t.ext_low  = slo;
        t.ext_high = shi;
      end
    end else if (tin.op == rlit_pkg::OP_READ && rd_hit) begin
      t.hit      = 1'b1;
      t.hit_idx  = rlit_pkg::IDX_BITS'(IDX);
      t.hit_low  = slo;
      t.hit_high = shi;
      t.run      = srun;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout <= '0;
    end else begin
      tout <= t;
    end
  end

endmodule

@@ hw/rtl/run_lumi_interval_tracker_unit.sv @@
// Run/lumi interval tracker: a chain of max(MASK_DEPTH, SEEN_DEPTH) cells.
// An accepted transaction walks the chain of registered cells; FINISH then loads the result.
// One transaction at a time: item_stall holds the input until that result is loaded.
// Reset: both table counts to zero, chain and output empty; entries not cleared.
// Depends on rlit_pkg and rlit_cell.
module run_lumi_interval_tracker_unit #(
  parameter int MASK_DEPTH = rlit_pkg::MASK_DEPTH_DEF,
  parameter int SEEN_DEPTH = rlit_pkg::SEEN_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  rlit_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output rlit_pkg::result_t result
);

  localparam int CHAIN  = (MASK_DEPTH > SEEN_DEPTH) ? MASK_DEPTH : SEEN_DEPTH;
  localparam int MCNT_W = $clog2(MASK_DEPTH + 1);
  localparam int SCNT_W = $clog2(SEEN_DEPTH + 1);

  rlit_pkg::state_t  state;
  rlit_pkg::state_t  state_next;
  logic [MCNT_W-1:0] mask_count;
  logic [MCNT_W-1:0] mask_count_next;
  logic [SCNT_W-1:0] seen_count;
  logic [SCNT_W-1:0] seen_count_next;
  rlit_pkg::token_t  tail;
  rlit_pkg::token_t  tok [CHAIN+1];
  logic [CHAIN-1:0]  tok_vld;
  rlit_pkg::wr_t     wr;
  rlit_pkg::result_t res_next;
  logic              res_load;
  logic              accept;
  logic              out_free;

  assign item_stall = (state != rlit_pkg::S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    tok[0]            = '0;
    tok[0].valid      = accept;
    tok[0].op         = rlit_pkg::op_t'(item.operation);
    tok[0].run        = item.run_number;
    tok[0].lumi       = item.event_lumi;
    tok[0].range_low  = item.range_low;
    tok[0].range_high = item.range_high;
    tok[0].read_index = item.read_index;
  end

  for (genvar g = 0; g < CHAIN; g++) begin : g_cell
    rlit_cell #(
      .IDX    (g),
      .MCNT_W (MCNT_W),
      .SCNT_W (SCNT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .mask_count (mask_count),
      .seen_count (seen_count),
      .wr         (wr),
      .tin        (tok[g]),
      .tout       (tok[g+1])
    );
    assign tok_vld[g] = tok[g+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rlit_pkg::S_IDLE;
      mask_count <= '0;
      seen_count <= '0;
    end else begin
      state      <= state_next;
      mask_count <= mask_count_next;
      seen_count <= seen_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rlit_pkg::S_SCAN && tok[CHAIN].valid) begin
      tail <= tok[CHAIN];
    end
  end

  always_comb begin
    state_next      = state;
    mask_count_next = mask_count;
    seen_count_next = seen_count;
    wr              = '0;
    res_next        = '0;
    res_load        = 1'b0;
    unique case (state)
      rlit_pkg::S_IDLE: begin
        if (accept) begin
          state_next = rlit_pkg::S_SCAN;
        end
      end
      rlit_pkg::S_SCAN: begin
        if (tok[CHAIN].valid) begin
          state_next = rlit_pkg::S_FINISH;
        end
      end
      rlit_pkg::S_FINISH: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = rlit_pkg::S_IDLE;
          unique case (tail.op)
            rlit_pkg::OP_LOAD: begin
              if (int'(mask_count) >= MASK_DEPTH) begin
                res_next.status = rlit_pkg::ST_MASK_FULL;
              end else begin
                wr.mask_we      = 1'b1;
                wr.idx          = rlit_pkg::IDX_BITS'(mask_count);
                wr.run          = tail.run;
                wr.low          = tail.range_low;
                wr.high         = tail.range_high;
                mask_count_next = mask_count + MCNT_W'(1);
                res_next.status = rlit_pkg::ST_MASK_LOADED;
              end
            end
            rlit_pkg::OP_READ: begin
              res_next.status = rlit_pkg::ST_READ;
              if (tail.hit) begin
                res_next.entry_index = tail.hit_idx[rlit_pkg::RIDX_BITS-1:0];
                res_next.entry_valid = 1'b1;
                res_next.entry_run   = tail.run;
                res_next.entry_low   = tail.hit_low;
                res_next.entry_high  = tail.hit_high;
              end
            end
            rlit_pkg::OP_CLEAR: begin
              mask_count_next = '0;
              seen_count_next = '0;
              res_next.status = rlit_pkg::ST_CLEARED;
            end
            rlit_pkg::OP_EVENT: begin
              priority if (mask_count != '0 && !tail.mask_hit) begin
                res_next.status = rlit_pkg::ST_MASKED;
              end else if (tail.hit) begin
                res_next.status      = rlit_pkg::ST_COVERED;
                res_next.entry_index = tail.hit_idx[rlit_pkg::RIDX_BITS-1:0];
                res_next.entry_valid = 1'b1;
                res_next.entry_run   = tail.run;
                res_next.entry_low   = tail.hit_low;
                res_next.entry_high  = tail.hit_high;
              end else if (tail.ext) begin
                wr.seen_we           = 1'b1;
                wr.idx               = tail.ext_idx;
                wr.run               = tail.run;
                wr.low               = tail.ext_hi ? tail.ext_low : tail.lumi;
                wr.high              = tail.ext_hi ? tail.lumi : tail.ext_high;
                res_next.status      = tail.ext_hi ? rlit_pkg::ST_HIGH_EXT
                                                   : rlit_pkg::ST_LOW_EXT;
                res_next.entry_index = tail.ext_idx[rlit_pkg::RIDX_BITS-1:0];
                res_next.entry_valid = 1'b1;
                res_next.entry_run   = tail.run;
                res_next.entry_low   = wr.low;
                res_next.entry_high  = wr.high;
              end else if (int'(seen_count) >= SEEN_DEPTH) begin
                res_next.status = rlit_pkg::ST_FULL;
              end else begin
                wr.seen_we           = 1'b1;
                wr.idx               = rlit_pkg::IDX_BITS'(seen_count);
                wr.run               = tail.run;
                wr.low               = tail.lumi;
                wr.high              = tail.lumi;
                seen_count_next      = seen_count + SCNT_W'(1);
                res_next.status      = rlit_pkg::ST_NEW;
                res_next.entry_index = rlit_pkg::RIDX_BITS'(seen_count);
                res_next.entry_valid = 1'b1;
                res_next.entry_run   = tail.run;
                res_next.entry_low   = tail.lumi;
                res_next.entry_high  = tail.lumi;
              end
            end
            default: begin
              res_next.status = rlit_pkg::ST_CLEARED;
            end
          endcase
        end
      end
      default: begin
        state_next = rlit_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vld))
    else $error("more than one transaction in the cell chain");

  a_chain_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    (tok_vld != '0) |-> (state == rlit_pkg::S_SCAN))
    else $error("chain busy outside scan state");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == rlit_pkg::S_SCAN))
    else $error("accepted transaction did not start a scan");

  a_mask_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(mask_count) <= MASK_DEPTH)
    else $error("mask count past depth");

  a_seen_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(seen_count) <= SEEN_DEPTH)
    else $error("seen count past depth");

endmodule

@@ dv/run_lumi_interval_tracker_unit_tb.sv @@
// Self-checking testbench for run_lumi_interval_tracker_unit: mask loads, events, reads
// and clears, with random idling on both channels and a long result hold-off.
// Depends on rlit_pkg and the tracker RTL.
module run_lumi_interval_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MASK_SLOTS   = rlit_pkg::MASK_DEPTH_DEF;
  localparam int SEEN_SLOTS   = rlit_pkg::SEEN_DEPTH_DEF;
  localparam int ITEM_TARGET  = 1100;
  localparam int HOLD_CYCLES  = 700;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 500000;

  class lumi_interval_book;
    logic [rlit_pkg::RUN_BITS-1:0]  mask_run  [MASK_SLOTS];
    logic [rlit_pkg::LUMI_BITS-1:0] mask_low  [MASK_SLOTS];
    logic [rlit_pkg::LUMI_BITS-1:0] mask_high [MASK_SLOTS];
    logic [rlit_pkg::RUN_BITS-1:0]  seen_run  [SEEN_SLOTS];
    logic [rlit_pkg::LUMI_BITS-1:0] seen_low  [SEEN_SLOTS];
    logic [rlit_pkg::LUMI_BITS-1:0] seen_high [SEEN_SLOTS];
    int mask_used;
    int seen_used;
    int failures;
    rlit_pkg::result_t awaited_results [$];

    function new();
      mask_used = 0;
      seen_used = 0;
      failures  = 0;
    endfunction

    function void report_failure(string what);
      failures++;
      if (failures <= 10) begin
        $display("%s", what);
      end
    endfunction

    function rlit_pkg::result_t entry_report(rlit_pkg::status_t st, int slot);
      rlit_pkg::result_t r;
      r = '0;
      r.status = st;
      if (slot >= 0) begin
        r.entry_index = slot[rlit_pkg::RIDX_BITS-1:0];
        r.entry_valid = 1'b1;
        r.entry_run   = seen_run[slot];
        r.entry_low   = seen_low[slot];
        r.entry_high  = seen_high[slot];
      end
      return r;
    endfunction

    function void note_item(rlit_pkg::item_t it);
      rlit_pkg::result_t              r;
      logic [rlit_pkg::RUN_BITS-1:0]  run;
      logic [rlit_pkg::LUMI_BITS-1:0] lumi;
      bit                             allowed;
      int                             slot;
      rlit_pkg::status_t              st;
      run  = it.run_number;
      lumi = it.event_lumi;
      case (rlit_pkg::op_t'(it.operation))
        rlit_pkg::OP_LOAD: begin
          if (mask_used >= MASK_SLOTS) begin
            r = entry_report(rlit_pkg::ST_MASK_FULL, -1);
          end else begin
            mask_run[mask_used]  = run;
            mask_low[mask_used]  = it.range_low;
            mask_high[mask_used] = it.range_high;
            mask_used++;
            r = entry_report(rlit_pkg::ST_MASK_LOADED, -1);
          end
        end
        rlit_pkg::OP_READ: begin
          slot = (int'(it.read_index) < seen_used) ? int'(it.read_index) : -1;
          r = entry_report(rlit_pkg::ST_READ, slot);
        end
        rlit_pkg::OP_CLEAR: begin
          mask_used = 0;
          seen_used = 0;
          r = entry_report(rlit_pkg::ST_CLEARED, -1);
        end
        rlit_pkg::OP_EVENT: begin
          allowed = (mask_used == 0);
          for (int i = 0; i < mask_used; i++) begin
            if (mask_run[i] == run && mask_low[i] <= lumi && mask_high[i] >= lumi) begin
              allowed = 1'b1;
            end
          end
          if (!allowed) begin
            r = entry_report(rlit_pkg::ST_MASKED, -1);
          end else begin
            slot = -1;
            st   = rlit_pkg::ST_NEW;
            for (int i = 0; i < seen_used && slot < 0; i++) begin
              if (seen_run[i] == run && seen_low[i] <= lumi && seen_high[i] >= lumi) begin
                slot = i;
                st   = rlit_pkg::ST_COVERED;
              end
            end
            // first entry of the run touched at either end grows by one
            for (int i = 0; i < seen_used && slot < 0; i++) begin
              if (seen_run[i] == run) begin
                if (lumi != rlit_pkg::LUMI_MAX && seen_low[i] == lumi + 1'b1) begin
                  seen_low[i] = lumi;
                  slot = i;
                  st   = rlit_pkg::ST_LOW_EXT;
                end else if (lumi != '0 && seen_high[i] == lumi - 1'b1) begin
                  seen_high[i] = lumi;
                  slot = i;
                  st   = rlit_pkg::ST_HIGH_EXT;
                end
              end
            end
            if (slot < 0) begin
              if (seen_used >= SEEN_SLOTS) begin
                st = rlit_pkg::ST_FULL;
              end else begin
                seen_run[seen_used]  = run;
                seen_low[seen_used]  = lumi;
                seen_high[seen_used] = lumi;
                slot = seen_used;
                seen_used++;
              end
            end
            r = entry_report(st, slot);
          end
        end
      endcase
      awaited_results = {awaited_results, r};
    endfunction

    function void check_result(rlit_pkg::result_t got);
      rlit_pkg::result_t want;
      if (awaited_results.size() == 0) begin
        report_failure($sformatf("unexpected result: status %0d idx %0d", got.status,
                                 got.entry_index));
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.entry_index !== want.entry_index ||
          got.entry_valid !== want.entry_valid || got.entry_run !== want.entry_run ||
          got.entry_low !== want.entry_low || got.entry_high !== want.entry_high) begin
        report_failure({
          $sformatf("mismatch: exp st %0d idx %0d v %0b run %h lo %h hi %h",
                    want.status, want.entry_index, want.entry_valid, want.entry_run,
                    want.entry_low, want.entry_high),
          $sformatf(" / got st %0d idx %0d v %0b run %h lo %h hi %h",
                    got.status, got.entry_index, got.entry_valid, got.entry_run,
                    got.entry_low, got.entry_high)});
      end
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    function void finish_check();
      if (awaited_results.size() != 0) begin
        report_failure($sformatf("%0d results never arrived", awaited_results.size()));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  rlit_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  rlit_pkg::result_t result;

  lumi_interval_book book = new();
  int  items_sent  = 0;
  int  cycle_count = 0;
  bit  quiet_phase = 1'b0;
  bit  hold_off    = 1'b0;

  run_lumi_interval_tracker_unit #(
    .MASK_DEPTH(MASK_SLOTS),
    .SEEN_DEPTH(SEEN_SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic rlit_pkg::item_t random_item();
    logic [95:0] bits;
    bits = {$urandom(), $urandom(), $urandom()};
    return bits[$bits(rlit_pkg::item_t)-1:0];
  endfunction

  task automatic send_item(rlit_pkg::item_t it);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall !== 1'b0);
    book.note_item(it);
    items_sent++;
  endtask

  task automatic send_event(logic [rlit_pkg::RUN_BITS-1:0] run,
                            logic [rlit_pkg::LUMI_BITS-1:0] lumi);
    rlit_pkg::item_t it;
    it = random_item();
    it.operation  = rlit_pkg::OP_EVENT;
    it.run_number = run;
    it.event_lumi = lumi;
    send_item(it);
  endtask

  task automatic send_load(logic [rlit_pkg::RUN_BITS-1:0] run,
                           logic [rlit_pkg::LUMI_BITS-1:0] lo,
                           logic [rlit_pkg::LUMI_BITS-1:0] hi);
    rlit_pkg::item_t it;
    it = random_item();
    it.operation  = rlit_pkg::OP_LOAD;
    it.run_number = run;
    it.range_low  = lo;
    it.range_high = hi;
    send_item(it);
  endtask

  task automatic send_read(logic [rlit_pkg::RIDX_BITS-1:0] idx);
    rlit_pkg::item_t it;
    it = random_item();
    it.operation  = rlit_pkg::OP_READ;
    it.read_index = idx;
    send_item(it);
  endtask

  task automatic send_clear();
    rlit_pkg::item_t it;
    it = random_item();
    it.operation = rlit_pkg::OP_CLEAR;
    send_item(it);
  endtask

  // mostly proper ranges near base, some with low above high
  task automatic send_random_range(logic [rlit_pkg::RUN_BITS-1:0] run,
                                   logic [rlit_pkg::LUMI_BITS-1:0] base, int spread);
    logic [rlit_pkg::LUMI_BITS-1:0] lo;
    lo = base + rlit_pkg::LUMI_BITS'($urandom_range(0, spread));
    if ($urandom_range(0, 7) == 0) begin
      send_load(run, lo, lo - rlit_pkg::LUMI_BITS'($urandom_range(1, 20)));
    end else begin
      send_load(run, lo, lo + rlit_pkg::LUMI_BITS'($urandom_range(0, 40)));
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    result_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      @(posedge clk);
      if (result_valid === 1'b1 && !result_stall) begin
        book.check_result(result);
        stall_left = quiet_phase ? 0 : $urandom_range(0, 15);
      end else if (result_valid === 1'b1 && stall_left > 0) begin
        stall_left--;
      end
      result_stall <= hold_off || stall_left > 0;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (items_sent >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [rlit_pkg::RUN_BITS-1:0]  runs [4];
    logic [rlit_pkg::RUN_BITS-1:0]  r1;
    logic [rlit_pkg::RUN_BITS-1:0]  r2;
    logic [rlit_pkg::LUMI_BITS-1:0] base;
    int                             kind;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    r1 = $urandom();
    r2 = $urandom();
    send_read(0);
    send_event(r1, 100);
    send_event(r1, 100);
    send_event(r1, 99);
    send_event(r1, 101);
    send_event(r2, 100);
    // no wrap at the lumi bounds
    send_event('0, 0);
    send_event('0, rlit_pkg::LUMI_MAX);
    send_event('1, rlit_pkg::LUMI_MAX);
    send_event('1, 0);
    send_event('0, 1);
    send_event('0, rlit_pkg::LUMI_MAX - 1'b1);
    // neighbors stay separate entries
    send_event(r2, 10);
    send_event(r2, 12);
    send_event(r2, 11);
    send_event(r2, 12);
    send_read(1);
    send_read(63);
    send_load(r1, 300, 200);
    send_load(r1, 90, 110);
    send_event(r1, 105);
    send_event(r1, 250);
    send_event(r2, 100);
    send_clear();
    send_read(0);
    send_event(r2, 7);

    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      quiet_phase <= ($urandom_range(0, 3) == 0);
      base = rlit_pkg::LUMI_BITS'($urandom());
      foreach (runs[k]) begin
        runs[k] = ($urandom_range(0, 7) == 0) ? {rlit_pkg::RUN_BITS{k[0]}} : $urandom();
      end
      if (kind < 8 && $urandom_range(0, 4) != 0) begin
        send_clear();
      end
      if (kind <= 3) begin
        if ($urandom_range(0, 1) == 1) begin
          repeat ($urandom_range(1, 6)) send_random_range(runs[$urandom_range(0, 3)], base, 30);
        end
        repeat ($urandom_range(40, 100)) begin
          if ($urandom_range(0, 9) == 0) begin
            send_read(rlit_pkg::RIDX_BITS'($urandom_range(0, 63)));
          end else begin
            send_event(runs[$urandom_range(0, 3)],
                       base + rlit_pkg::LUMI_BITS'($urandom_range(0, 40)));
          end
        end
      end else if (kind <= 5) begin
        repeat ($urandom_range(70, 100)) begin
          send_event(runs[$urandom_range(0, 1)],
                     base + rlit_pkg::LUMI_BITS'(2 * $urandom_range(0, 200)));
        end
        repeat (6) send_read(rlit_pkg::RIDX_BITS'($urandom_range(0, 63)));
      end else if (kind <= 7) begin
        repeat ($urandom_range(55, 70)) send_random_range(runs[$urandom_range(0, 3)], base, 300);
        repeat ($urandom_range(20, 40)) begin
          send_event(runs[$urandom_range(0, 3)],
                     base + rlit_pkg::LUMI_BITS'($urandom_range(0, 400)));
        end
      end else begin
        repeat ($urandom_range(15, 40)) send_item(random_item());
      end
    end

    item_valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    book.finish_check();
    if (book.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
